[rtl/core/ita_pkg.sv]
// ----------------------------------------------------------------------------
// ita_pkg: shared types and constants for the integer-to-ASCII converter
// Conversion codes, the start record passed to the character sequencer and
// the ASCII codes of the fixed characters.
// ----------------------------------------------------------------------------
package ita_pkg;

  typedef enum logic [1:0] {
    ACT_DEC   = 2'd0,
    ACT_HEX   = 2'd1,
    ACT_BIN   = 2'd2,
    ACT_MONEY = 2'd3
  } action_e;

  // Start record for the character sequencer
  typedef struct packed {
    action_e act;
    logic    neg;
  } start_t;

  localparam logic [6:0] CH_ZERO       = 7'd48;   // '0'
  localparam logic [6:0] CH_ALPHA_BASE = 7'd87;   // 'W', so that 10 maps to 'a'
  localparam logic [6:0] CH_MINUS      = 7'd45;   // '-'
  localparam logic [6:0] CH_DOT        = 7'd46;   // '.'
  localparam logic [6:0] CH_DOLLAR     = 7'd36;   // '$'
  localparam logic [6:0] CH_X          = 7'd120;  // 'x'
  localparam logic [6:0] CH_B          = 7'd98;   // 'b'

  // ASCII code of one digit, lowercase above nine
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {3'b000, d};
    end else begin
      r = CH_ALPHA_BASE + {3'b000, d};
    end
    return r;
  endfunction

endpackage

[rtl/core/ita_dabble.sv]
// ----------------------------------------------------------------------------
// ita_dabble: bit-serial binary to BCD converter
// Shifts the magnitude in one bit per cycle, most significant first, and
// corrects every BCD digit of five or more by three before each shift.
// ----------------------------------------------------------------------------
module ita_dabble #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       load_i,
  input  logic [VALUE_WIDTH-1:0]                     mag_i,
  output logic [4*((VALUE_WIDTH*3)/10+1)-1:0]        bcd_o,
  output logic                                       done_o
);
  localparam int NDIG = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int SW   = 4 * NDIG;
  localparam int CW   = $clog2(VALUE_WIDTH + 1);

  logic                   run_q, run_d;
  logic                   done_q, done_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [SW-1:0]          bcd_q, bcd_d;
  logic [SW-1:0]          adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (load_i) begin
      run_d = 1'b1;
      cnt_d = CW'(VALUE_WIDTH);
      bin_d = mag_i;
      bcd_d = '0;
    end else if (run_q) begin
      bcd_d = {adj[SW-2:0], bin_q[VALUE_WIDTH-1]};
      bin_d = bin_q << 1;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign bcd_o  = bcd_q;
  assign done_o = done_q;

endmodule

[rtl/core/ita_fmt.sv]
// ----------------------------------------------------------------------------
// ita_fmt: character sequencer with output register
// Emits sign, prefix, digits and the money tail one character per transfer,
// shifting the digits one per cycle unless stalled, skipping leading zeros.
// ----------------------------------------------------------------------------
module ita_fmt #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  ita_pkg::start_t                      ctrl_i,
  input  logic [VALUE_WIDTH-1:0]               mag_i,
  input  logic [4*((VALUE_WIDTH*3)/10+1)-1:0]  bcd_i,
  output logic                                 busy_o,
  output logic                                 char_valid_o,
  input  logic                                 char_ready_i,
  output logic [6:0]                           char_code_o,
  output logic                                 char_last_o
);
  import ita_pkg::*;

  localparam int NDIG = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int SW   = 4 * NDIG;
  localparam int NHEX = (VALUE_WIDTH + 3) / 4;
  localparam int HW   = 4 * NHEX;
  localparam int CW   = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_SIGN    = 8'b0000_0010,
    PH_PRE0    = 8'b0000_0100,
    PH_PRE1    = 8'b0000_1000,
    PH_DIGIT   = 8'b0001_0000,
    PH_DOT     = 8'b0010_0000,
    PH_CENT_HI = 8'b0100_0000,
    PH_CENT_LO = 8'b1000_0000
  } phase_e;

  phase_e        phase_q, phase_d, nxt;
  action_e       act_q, act_d;
  logic          seen_q, seen_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] dig_q, dig_d;
  logic          ov_q, ov_d;
  logic [6:0]    oc_q, oc_d;
  logic          ol_q, ol_d;

  logic          slot_free, emit, lst, shift_en, adv;
  logic          dig_nz, last_dig;
  logic [3:0]    top_dig;
  logic [6:0]    ch;
  logic [HW-1:0] hex_ext;

  assign slot_free = !ov_q || char_ready_i;
  assign top_dig   = (act_q == ACT_BIN) ? {3'b000, dig_q[SW-1]} : dig_q[SW-1 -: 4];
  assign dig_nz    = (top_dig != 4'd0);
  assign last_dig  = (cnt_q == CW'(1));
  assign hex_ext   = HW'(mag_i);

  // Per-phase character and successor
  always_comb begin
    emit     = 1'b0;
    ch       = CH_ZERO;
    lst      = 1'b0;
    shift_en = 1'b0;
    nxt      = phase_q;
    unique case (phase_q)
      PH_IDLE: begin
        nxt = PH_IDLE;
      end
      PH_SIGN: begin
        emit = 1'b1;
        ch   = CH_MINUS;
        nxt  = (act_q == ACT_DEC) ? PH_DIGIT : PH_PRE0;
      end
      PH_PRE0: begin
        emit = 1'b1;
        ch   = (act_q == ACT_MONEY) ? CH_DOLLAR : CH_ZERO;
        nxt  = (act_q == ACT_MONEY) ? PH_DIGIT : PH_PRE1;
      end
      PH_PRE1: begin
        emit = 1'b1;
        ch   = (act_q == ACT_HEX) ? CH_X : CH_B;
        nxt  = PH_DIGIT;
      end
      PH_DIGIT: begin
        emit     = seen_q || dig_nz || last_dig;
        ch       = digit_char(top_dig);
        lst      = last_dig && (act_q != ACT_MONEY);
        shift_en = 1'b1;
        if (last_dig) begin
          nxt = (act_q == ACT_MONEY) ? PH_DOT : PH_IDLE;
        end
      end
      PH_DOT: begin
        emit = 1'b1;
        ch   = CH_DOT;
        nxt  = PH_CENT_HI;
      end
      PH_CENT_HI: begin
        emit     = 1'b1;
        ch       = digit_char(top_dig);
        shift_en = 1'b1;
        nxt      = PH_CENT_LO;
      end
      PH_CENT_LO: begin
        emit = 1'b1;
        ch   = digit_char(top_dig);
        lst  = 1'b1;
        nxt  = PH_IDLE;
      end
      default: begin
        nxt = PH_IDLE;
      end
    endcase
  end

  // Advance when the character is taken, or at once for a skipped zero
  assign adv = (phase_q != PH_IDLE) && (!emit || slot_free);

  always_comb begin
    phase_d = phase_q;
    act_d   = act_q;
    seen_d  = seen_q;
    cnt_d   = cnt_q;
    dig_d   = dig_q;
    ov_d    = ov_q;
    oc_d    = oc_q;
    ol_d    = ol_q;

    if (phase_q == PH_IDLE) begin
      if (start_i) begin
        act_d  = ctrl_i.act;
        seen_d = 1'b0;
        case (ctrl_i.act)
          ACT_HEX: begin
            dig_d = SW'(hex_ext) << (SW - HW);
            cnt_d = CW'(NHEX);
          end
          ACT_BIN: begin
            dig_d = SW'(mag_i) << (SW - VALUE_WIDTH);
            cnt_d = CW'(VALUE_WIDTH);
          end
          ACT_MONEY: begin
            dig_d = bcd_i;
            cnt_d = CW'(NDIG - 2);
          end
          default: begin
            dig_d = bcd_i;
            cnt_d = CW'(NDIG);
          end
        endcase
        if (ctrl_i.neg) begin
          phase_d = PH_SIGN;
        end else if (ctrl_i.act == ACT_DEC) begin
          phase_d = PH_DIGIT;
        end else begin
          phase_d = PH_PRE0;
        end
      end
    end else if (adv) begin
      phase_d = nxt;
      if (shift_en) begin
        dig_d = (act_q == ACT_BIN) ? (dig_q << 1) : (dig_q << 4);
      end
      if (phase_q == PH_DIGIT) begin
        cnt_d  = cnt_q - CW'(1);
        seen_d = seen_q || dig_nz;
      end
    end

    if (slot_free) begin
      ov_d = emit && (phase_q != PH_IDLE);
      oc_d = ch;
      ol_d = lst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ov_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    seen_q <= seen_d;
    cnt_q  <= cnt_d;
    dig_q  <= dig_d;
    oc_q   <= oc_d;
    ol_q   <= ol_d;
  end

  assign busy_o       = (phase_q != PH_IDLE);
  assign char_valid_o = ov_q;
  assign char_code_o  = oc_q;
  assign char_last_o  = ol_q;

endmodule

[rtl/core/integer_to_ascii_radix.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: signed integer to ASCII text in four formats
// Decimal, hex with "0x", binary with "0b", or money ("$", units, ".", cents).
// A negative value leads with '-'. One character leaves per output transfer.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | tdata (lowest bit up)              | tlast / tuser
//  ---------+-----------+------------------------------------+-------------------
//  s_axis   | in        | action[1:0], value[VALUE_WIDTH-1:0] | none
//  m_axis   | out       | char_code[6:0], one zero pad bit    | tlast = last char
//
//  An item is taken only while the block is idle. Decimal and money pass
//  through the bit-serial BCD converter (the shifts, then a done pulse), then
//  the sequencer steps through every BCD digit slot ((VALUE_WIDTH*3)/10+1,
//  leading zeros included) and each sign, prefix or money character. Hex
//  steps through each nibble ((VALUE_WIDTH+3)/4) and binary each bit, plus
//  sign and prefix. The control then returns to idle.
//  Reset clears the control state only; no clearing pass is needed.
//  A stalled m_axis holds the sequencer; the output register lets the last
//  character wait while the next item is taken.
//
module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // action[1:0], value[VALUE_WIDTH+1:2], zero pad above
  input  logic [((VALUE_WIDTH+2+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // char_code[6:0], zero at bit 7
  output logic [7:0]                             m_axis_tdata,
  output logic                                   m_axis_tlast
);
  import ita_pkg::*;

  localparam int NDIG = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int SW   = 4 * NDIG;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  action_e                act_q;
  logic                   neg_q;

  action_e                in_act;
  logic [VALUE_WIDTH-1:0] in_val, in_mag;
  logic                   in_neg, in_radix2, acc;

  logic                   dab_load, dab_done;
  logic [SW-1:0]          bcd;
  logic                   fmt_start, fmt_busy;
  start_t                 fmt_ctrl;
  logic [6:0]             char_code;

  // Unpack the input and form the unsigned magnitude
  assign in_act    = action_e'(s_axis_tdata[1:0]);
  assign in_val    = s_axis_tdata[VALUE_WIDTH+1:2];
  assign in_neg    = in_val[VALUE_WIDTH-1];
  assign in_mag    = in_neg ? (~in_val + VALUE_WIDTH'(1)) : in_val;
  assign in_radix2 = (in_act == ACT_HEX) || (in_act == ACT_BIN);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Decimal and money go through the BCD converter first
  assign dab_load = acc && !in_radix2;

  // Hex and binary start the sequencer at once from the input
  assign fmt_start = (acc && in_radix2) || ((state_q == ST_CONV) && dab_done);
  always_comb begin
    if (state_q == ST_IDLE) begin
      fmt_ctrl.act = in_act;
      fmt_ctrl.neg = in_neg;
    end else begin
      fmt_ctrl.act = act_q;
      fmt_ctrl.neg = neg_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          state_d = in_radix2 ? ST_EMIT : ST_CONV;
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!fmt_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the conversion code and sign for the converter's finish
  always_ff @(posedge clk_i) begin
    if (acc) begin
      act_q <= in_act;
      neg_q <= in_neg;
    end
  end

  ita_dabble #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (dab_load),
    .mag_i  (in_mag),
    .bcd_o  (bcd),
    .done_o (dab_done)
  );

  ita_fmt #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_fmt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (fmt_start),
    .ctrl_i       (fmt_ctrl),
    .mag_i        (in_mag),
    .bcd_i        (bcd),
    .busy_o       (fmt_busy),
    .char_valid_o (m_axis_tvalid),
    .char_ready_i (m_axis_tready),
    .char_code_o  (char_code),
    .char_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, char_code};

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for integer_to_ascii_radix
// Sends signed values in every conversion format over the input stream.
// Predicts the character string for each accepted value and compares every
// output transfer with it in order. Runs a directed pass first, then random
// passes with varying idle patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import ita_pkg::*;

  localparam int VW        = 32;
  localparam int IN_BITS   = ((VW + 2 + 7) / 8) * 8;
  localparam int SETTLE    = 60;    // converter latency plus margin
  localparam int HOLD_LONG = 400;   // long output hold-off, in cycles

  // One expected character: code and end-of-string flag
  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } char_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // action[1:0], value[33:2], zero pad above
  logic [IN_BITS-1:0] s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // char_code[6:0], zero at bit 7
  logic [7:0]         m_axis_tdata;
  logic               m_axis_tlast;

  char_t       pending_chars[$];  // characters still owed by the block
  logic [6:0]  text_q[$];         // scratch string for one conversion
  int          error_count = 0;
  int          src_idle_pct = 0;
  int          dst_idle_pct = 0;
  int          hold_left = 0;

  integer_to_ascii_radix #(
    .VALUE_WIDTH(VW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Append the digits of mag in the given radix, most significant first,
  // with no leading zeros; zero still yields one digit.
  function automatic void append_digits(input logic [31:0] mag, input logic [31:0] radix);
    logic [6:0]  rev[$];
    logic [31:0] d;
    rev = {};
    do begin
      d = mag % radix;
      if (d < 32'd10) begin
        rev.push_front(CH_ZERO + d[6:0]);
      end else begin
        rev.push_front(CH_ALPHA_BASE + d[6:0]);
      end
      mag = mag / radix;
    end while (mag != 32'd0);
    foreach (rev[i]) text_q.push_back(rev[i]);
  endfunction

  // Build the full string for one value and queue it as expected characters
  function automatic void predict_text(input action_e act, input logic [31:0] value);
    logic [31:0] mag;
    logic [31:0] cents;
    text_q = {};
    // Unsigned negation keeps the most negative value intact
    mag = value[31] ? (~value + 32'd1) : value;
    if (value[31]) text_q.push_back(CH_MINUS);
    case (act)
      ACT_DEC: begin
        append_digits(mag, 32'd10);
      end
      ACT_HEX: begin
        text_q.push_back(CH_ZERO);
        text_q.push_back(CH_X);
        append_digits(mag, 32'd16);
      end
      ACT_BIN: begin
        text_q.push_back(CH_ZERO);
        text_q.push_back(CH_B);
        append_digits(mag, 32'd2);
      end
      default: begin
        cents = mag % 32'd100;
        text_q.push_back(CH_DOLLAR);
        append_digits(mag / 32'd100, 32'd10);
        text_q.push_back(CH_DOT);
        text_q.push_back(CH_ZERO + 7'(cents / 32'd10));
        text_q.push_back(CH_ZERO + 7'(cents % 32'd10));
      end
    endcase
    foreach (text_q[i]) begin
      pending_chars.push_back('{code: text_q[i], last: (i == text_q.size() - 1)});
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: receiver stalls and result check
  // --------------------------------------------------------------------------

  // Drop tready for a requested hold-off, else stall at the current idle rate
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  // Compare every output transfer with the oldest expected character
  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected output transfer: char_code %0d last %0b",
               m_axis_tdata[6:0], m_axis_tlast);
        error_count = error_count + 1;
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata[6:0] !== want.code) begin
          $error("char_code mismatch: expected %0d actual %0d",
                 want.code, m_axis_tdata[6:0]);
          error_count = error_count + 1;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last mismatch: expected %0b actual %0b", want.last, m_axis_tlast);
          error_count = error_count + 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one value; called and returning at a falling edge
  task automatic send_item(input action_e act, input logic [31:0] value);
    // Idle the input at the current rate before offering
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_BITS - VW - 2){1'b0}}, value, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_text(act, value);
    @(negedge clk_i);
  endtask

  // Hold the input idle until every expected character has arrived
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Mix of full-range, small, power-of-two and near-extreme values
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 999);
      2: v = -$urandom_range(0, 999);
      3: v = 32'd1 << $urandom_range(0, 31);
      4: v = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_fff0) + $urandom_range(0, 15);
      default: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Extremes in every format, plus zero, cents below ten and lowercase hex
  task automatic test_directed();
    logic [31:0] corner[4];
    corner[0] = 32'd0;
    corner[1] = 32'hffff_ffff;
    corner[2] = 32'h7fff_ffff;
    corner[3] = 32'h8000_0000;
    src_idle_pct = 0;
    dst_idle_pct = 0;
    for (int a = 0; a < 4; a++) begin
      foreach (corner[i]) send_item(action_e'(a), corner[i]);
    end
    send_item(ACT_MONEY, 32'd5);
    send_item(ACT_MONEY, -32'd100);
    send_item(ACT_MONEY, 32'd99);
    send_item(ACT_HEX, 32'hdead_beef);
    send_item(ACT_DEC, 32'd10);
    send_item(ACT_BIN, -32'd1234);
    drain_results();
  endtask

  task automatic test_random(input int count, input int src_pct, input int dst_pct);
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    repeat (count) send_item(action_e'($urandom_range(0, 3)), pick_value());
    drain_results();
  endtask

  // Hold the output off for a long stretch while values keep coming, so the
  // block fills up and stalls its input
  task automatic test_output_hold();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_left = HOLD_LONG;
    repeat (15) send_item(action_e'($urandom_range(0, 3)), pick_value());
    drain_results();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(120, 15, 64);
    test_random(120, 64, 15);
    test_output_hold();
    test_random(115, 0, 0);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run well beyond the slowest correct one
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[integer_to_ascii_radix.f]
rtl/core/ita_pkg.sv
rtl/core/ita_dabble.sv
rtl/core/ita_fmt.sv
rtl/core/integer_to_ascii_radix.sv
verif/tb_top.sv
